@@ rtl/ssrc_pkg.sv @@
// ----------------------------------------------------------------------------
// ssrc_pkg: stepper speed ramp controller shared definitions
// Field widths, fixed-point constants, op codes and register indexes.
// ----------------------------------------------------------------------------
package ssrc_pkg;

	localparam int unsigned TIMER_RATE      = 1000000;
	localparam int unsigned SPEED_FRAC_BITS = 8;

	localparam int unsigned TGT_W    = 16;
	localparam int unsigned SPEED_W  = TGT_W + SPEED_FRAC_BITS;
	localparam int unsigned RATE_W   = 15;
	localparam int unsigned DELTA_W  = 23;
	localparam int unsigned CODE_W   = 3;
	localparam int unsigned PERIOD_W = 20;
	localparam int unsigned ADDR_W   = 5;
	localparam int unsigned DATA_W   = 32;

	// largest log2 microstep factor, the frequency width that follows from it and the dividend width
	localparam logic [CODE_W-1:0] MAX_CODE = 3'd5;
	localparam int unsigned FREQ_W = RATE_W + 5;
	localparam int unsigned DVD_W  = $clog2(TIMER_RATE + 1);

	// speed thresholds for automatic microstep selection, Q.8
	localparam logic [SPEED_W-1:0] LOW_THRESH_Q  = SPEED_W'(150 << SPEED_FRAC_BITS);
	localparam logic [SPEED_W-1:0] MED_THRESH_Q  = SPEED_W'(800 << SPEED_FRAC_BITS);
	localparam logic [SPEED_W-1:0] HIGH_THRESH_Q = SPEED_W'(1000 << SPEED_FRAC_BITS);

	localparam logic [CODE_W-1:0] CODE_SLOW   = 3'd4;
	localparam logic [CODE_W-1:0] CODE_MEDIUM = 3'd3;
	localparam logic [CODE_W-1:0] CODE_FAST   = 3'd2;
	localparam logic [CODE_W-1:0] CODE_FULL   = 3'd0;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd20000;

	localparam logic [RATE_W-1:0]  MAX_RATE_RESET = 15'd2000;
	localparam logic [RATE_W-1:0]  MIN_RATE_RESET = 15'd50;
	localparam logic [DELTA_W-1:0] DELTA_RESET    = 23'd2560;
	localparam logic [CODE_W-1:0]  INIT_CODE_RESET = 3'd1;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		REG_MAX_RATE  = 3'd0,
		REG_MIN_RATE  = 3'd1,
		REG_MAX_DELTA = 3'd2,
		REG_INIT_CODE = 3'd3,
		REG_AUTO      = 3'd4
	} reg_idx_t;

	// handshake between the sequencer and the period divider
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [CODE_W-1:0] clamp_code(input logic [CODE_W-1:0] c);
		return (c > MAX_CODE) ? MAX_CODE : c;
	endfunction

endpackage

@@ rtl/ssrc_div.sv @@
// ----------------------------------------------------------------------------
// ssrc_div: bit-serial period divider
// Restoring division of the timer rate by the step frequency, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module ssrc_div import ssrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FREQ_W-1:0] divisor,
	output div_stat_t         stat,
	output logic [DVD_W-1:0]  quotient
);

	localparam int unsigned CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0]  dvd_q;
	logic [FREQ_W-1:0] rem_q;
	logic [FREQ_W-1:0] dsr_q;
	logic [DVD_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [FREQ_W:0] trial;
	logic [FREQ_W:0] diff;
	logic            fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath needs no reset
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= DVD_W'(TIMER_RATE);
			rem_q <= '0;
			quo_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

@@ rtl/stepper_speed_ramp_controller.sv @@
// ----------------------------------------------------------------------------
// stepper_speed_ramp_controller: stepper acceleration ramp and STEP timing
// Sequence: start, stop, unused ops and ticks while stopped finish in the idle
//   state; a tick while running passes through the slew, step and rate states
//   and, when the clamped rate is nonzero, the 20-bit serial divider.
// Handshake: one request at a time, the next accepted once the result is
//   registered; a stall on the result channel holds the next request back.
// Reset: asynchronous, clears control state; registers return to defaults.
// ----------------------------------------------------------------------------
module stepper_speed_ramp_controller import ssrc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,
	// request channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                op,
	input  logic signed [TGT_W-1:0]   target_rate,
	// result channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      pulse_active,
	output logic                      direction,
	output logic [PERIOD_W-1:0]       step_period,
	output logic [CODE_W-1:0]         microstep_pins,
	output logic signed [SPEED_W-1:0] speed_now,
	output logic                      status
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SLEW = 5'b00010,
		S_STEP = 5'b00100,
		S_RATE = 5'b01000,
		S_DIV  = 5'b10000
	} state_t;

	localparam state_t S_DONE_UNUSED = S_IDLE;

	// configuration registers
	logic [RATE_W-1:0]  max_rate_q;
	logic [RATE_W-1:0]  min_rate_q;
	logic [DELTA_W-1:0] max_delta_q;
	logic [CODE_W-1:0]  init_code_q;
	logic               auto_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rate_q  <= MAX_RATE_RESET;
			min_rate_q  <= MIN_RATE_RESET;
			max_delta_q <= DELTA_RESET;
			init_code_q <= INIT_CODE_RESET;
			auto_q      <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_MAX_RATE:  max_rate_q  <= pwdata[RATE_W-1:0];
				REG_MIN_RATE:  min_rate_q  <= pwdata[RATE_W-1:0];
				REG_MAX_DELTA: max_delta_q <= pwdata[DELTA_W-1:0];
				REG_INIT_CODE: init_code_q <= pwdata[CODE_W-1:0];
				REG_AUTO:      auto_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_MAX_RATE:  prdata = DATA_W'(max_rate_q);
			REG_MIN_RATE:  prdata = DATA_W'(min_rate_q);
			REG_MAX_DELTA: prdata = DATA_W'(max_delta_q);
			REG_INIT_CODE: prdata = DATA_W'(init_code_q);
			REG_AUTO:      prdata = DATA_W'(auto_q);
			default:       prdata = '0;
		endcase
	end

	// sequencer and motion state
	state_t                    state_q;
	logic                      done_q;
	logic                      running_q;
	logic                      pulse_q;
	logic                      dir_q;
	logic                      dir_pend_q;
	logic [PERIOD_W-1:0]       period_q;
	logic [CODE_W-1:0]         code_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic                      status_q;
	logic signed [TGT_W-1:0]   tgt_q;
	logic signed [SPEED_W:0]   diff_q;
	logic [FREQ_W-1:0]         step_freq;

	logic                      out_valid_q;
	logic                      out_pulse_q;
	logic                      out_dir_q;
	logic [PERIOD_W-1:0]       out_period_q;
	logic [CODE_W-1:0]         out_code_q;
	logic signed [SPEED_W-1:0] out_speed_q;
	logic                      out_status_q;

	logic in_acc;
	logic out_free;

	assign in_ready = (state_q == S_IDLE) && !done_q;
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// slew limit
	logic signed [SPEED_W:0]   tq_ext;
	logic signed [SPEED_W:0]   lim_pos;
	logic signed [SPEED_W:0]   lim_neg;
	logic signed [SPEED_W:0]   step_amt;
	logic signed [SPEED_W:0]   speed_sum;

	assign tq_ext  = {tgt_q[TGT_W-1], tgt_q, SPEED_FRAC_BITS'(0)};
	assign lim_pos = $signed({2'b00, max_delta_q});
	assign lim_neg = -lim_pos;

	always_comb begin
		if (diff_q > lim_pos) begin
			step_amt = lim_pos;
		end else if (diff_q < lim_neg) begin
			step_amt = lim_neg;
		end else begin
			step_amt = diff_q;
		end
	end

	assign speed_sum = {speed_q[SPEED_W-1], speed_q} + step_amt;

	// magnitude, microstep selection and rate clamp
	logic [SPEED_W-1:0]                 mag;
	logic [SPEED_W-SPEED_FRAC_BITS-1:0] whole;
	logic [RATE_W-1:0]                  rate_sat;
	logic [RATE_W-1:0]                  rate_clip;
	logic [RATE_W-1:0]                  rate;
	logic [CODE_W-1:0]                  auto_code;
	logic [CODE_W-1:0]                  code_next;

	assign mag   = speed_q[SPEED_W-1] ? SPEED_W'(-speed_q) : SPEED_W'(speed_q);
	assign whole = mag[SPEED_W-1:SPEED_FRAC_BITS];

	always_comb begin
		if (mag < LOW_THRESH_Q) begin
			auto_code = CODE_SLOW;
		end else if (mag < MED_THRESH_Q) begin
			auto_code = CODE_MEDIUM;
		end else if (mag < HIGH_THRESH_Q) begin
			auto_code = CODE_FAST;
		end else begin
			auto_code = CODE_FULL;
		end
	end

	// factor only follows the automatic pick while auto mode is on and the speed is below the rate limit
	assign code_next = (auto_q && (mag < {1'b0, max_rate_q, SPEED_FRAC_BITS'(0)}))
		? auto_code : code_q;

	assign rate_sat  = whole[SPEED_W-SPEED_FRAC_BITS-1] ? {RATE_W{1'b1}}
		: whole[RATE_W-1:0];
	assign rate_clip = (rate_sat > max_rate_q) ? max_rate_q : rate_sat;
	assign rate      = (rate_clip < min_rate_q) ? '0 : rate_clip;

	// period divider
	div_stat_t          div_stat;
	logic [DVD_W-1:0]   quotient;
	logic               div_start;

	assign div_start = (state_q == S_RATE) && (rate != '0);

	ssrc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (step_freq),
		.stat     (div_stat),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tgt_q <= target_rate;
		end
		if (state_q == S_SLEW) begin
			diff_q <= tq_ext - {speed_q[SPEED_W-1], speed_q};
		end
	end

	assign step_freq = FREQ_W'(rate) << code_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			done_q     <= 1'b0;
			running_q  <= 1'b0;
			pulse_q    <= 1'b0;
			dir_q      <= 1'b0;
			dir_pend_q <= 1'b0;
			period_q   <= PERIOD_RESET;
			code_q     <= clamp_code(INIT_CODE_RESET);
			speed_q    <= '0;
			status_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						status_q <= 1'b0;
						done_q   <= 1'b1;
						unique case (op_t'(op))
							OP_TICK: begin
								if (running_q) begin
									state_q <= S_SLEW;
									done_q  <= 1'b0;
								end
							end
							OP_START: begin
								if (running_q) begin
									status_q <= 1'b1;
								end else begin
									running_q <= 1'b1;
									code_q    <= clamp_code(init_code_q);
								end
							end
							OP_STOP: begin
								if (running_q) begin
									speed_q   <= '0;
									pulse_q   <= 1'b0;
									running_q <= 1'b0;
								end
							end
							default: ;
						endcase
					end else if (done_q && out_free) begin
						done_q <= 1'b0;
					end
				end
				S_SLEW: state_q <= S_STEP;
				S_STEP: begin
					speed_q <= speed_sum[SPEED_W-1:0];
					state_q <= S_RATE;
				end
				S_RATE: begin
					code_q     <= code_next;
					dir_pend_q <= speed_q[SPEED_W-1];
					if (rate == '0) begin
						pulse_q <= 1'b0;
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						period_q <= (quotient == '0) ? PERIOD_W'(1) : PERIOD_W'(quotient);
						dir_q    <= dir_pend_q;
						pulse_q  <= 1'b1;
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
					end
				end
				default: state_q <= S_DONE_UNUSED;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_IDLE && done_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && done_q && out_free) begin
			out_pulse_q  <= pulse_q;
			out_dir_q    <= dir_q;
			out_period_q <= period_q;
			out_code_q   <= code_q;
			out_speed_q  <= speed_q;
			out_status_q <= status_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign pulse_active   = out_pulse_q;
	assign direction      = out_dir_q;
	assign step_period    = out_period_q;
	assign microstep_pins = out_code_q;
	assign speed_now      = out_speed_q;
	assign status         = out_status_q;

`ifndef SYNTHESIS
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("request accepted while busy");

	a_pulse_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_q |-> running_q)
		else $error("pulse train on while stopped");

	a_period_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		period_q != '0)
		else $error("step period is zero");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		code_q <= MAX_CODE)
		else $error("microstep code out of range");

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == S_DIV))
		else $error("divider busy outside divide state");
`endif

endmodule

@@ tb/tb_stepper_speed_ramp_controller.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stepper_speed_ramp_controller: ramp, microstep and STEP period checks
// Requests go in through a bursty valid/ready driver; a ramp predictor
// computes each expected result at acceptance and a monitor compares every
// result field by field. Register settings change between idle phases.
// ----------------------------------------------------------------------------
module tb_stepper_speed_ramp_controller;
	import ssrc_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned PHASE_REQS = 150;
	localparam longint RATE_CAP = (longint'(1) << RATE_W) - 1;
	localparam longint PERIOD_CAP = (longint'(1) << PERIOD_W) - 1;

	typedef struct packed {
		logic [1:0]              code;
		logic signed [TGT_W-1:0] tgt;
	} ramp_req_t;

	typedef struct packed {
		logic                      pulse;
		logic                      dir;
		logic [PERIOD_W-1:0]       period;
		logic [CODE_W-1:0]         pins;
		logic signed [SPEED_W-1:0] speed;
		logic                      status;
	} ramp_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = OP_TICK;
	logic signed [TGT_W-1:0] target_rate = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic pulse_active;
	logic direction;
	logic [PERIOD_W-1:0] step_period;
	logic [CODE_W-1:0] microstep_pins;
	logic signed [SPEED_W-1:0] speed_now;
	logic status;

	stepper_speed_ramp_controller DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// register shadows
	logic [RATE_W-1:0]  cfg_max_rate = MAX_RATE_RESET;
	logic [RATE_W-1:0]  cfg_min_rate = MIN_RATE_RESET;
	logic [DELTA_W-1:0] cfg_delta = DELTA_RESET;
	logic [CODE_W-1:0]  cfg_init_code = INIT_CODE_RESET;
	logic               cfg_auto = 1'b0;

	// ramp state mirror
	logic signed [SPEED_W-1:0] ramp_speed = '0;
	logic [CODE_W-1:0]         ramp_code = INIT_CODE_RESET;
	logic                      ramp_pulse = 1'b0;
	logic                      ramp_dir = 1'b0;
	logic                      ramp_running = 1'b0;
	logic [PERIOD_W-1:0]       ramp_period = PERIOD_RESET;

	ramp_req_t request_q[$];
	ramp_out_t ramp_expect_q[$];
	logic gen_running = 1'b0;
	int unsigned err_count = 0;
	int unsigned cycle_cnt = 0;

	task automatic log_mismatch(input string what, input longint got, input longint want);
		$display("%0t ERROR %s: got %0d expected %0d", $realtime, what, got, want);
		err_count++;
	endtask

	function automatic void predict_ramp(input logic [1:0] req_op,
			input logic signed [TGT_W-1:0] tgt);
		longint tq, d, lim, cur, mag, rate, freq, per;
		logic [CODE_W-1:0] pick;
		logic busy_start;
		ramp_out_t r;
		busy_start = 1'b0;
		if (req_op == OP_TICK && ramp_running) begin
			tq = longint'(tgt) <<< SPEED_FRAC_BITS;
			lim = longint'(cfg_delta);
			d = tq - longint'(ramp_speed);
			if (d > lim)
				d = lim;
			else if (d < -lim)
				d = -lim;
			cur = longint'(ramp_speed) + d;
			ramp_speed = SPEED_W'(cur);
			mag = (cur < 0) ? -cur : cur;
			if (cfg_auto) begin
				if (mag < longint'(LOW_THRESH_Q))
					pick = CODE_SLOW;
				else if (mag < longint'(MED_THRESH_Q))
					pick = CODE_MEDIUM;
				else if (mag < longint'(HIGH_THRESH_Q))
					pick = CODE_FAST;
				else
					pick = CODE_FULL;
				// factor only moves while below the rate ceiling
				if (mag < (longint'(cfg_max_rate) << SPEED_FRAC_BITS))
					ramp_code = pick;
			end
			rate = mag >>> SPEED_FRAC_BITS;
			if (rate > RATE_CAP)
				rate = RATE_CAP;
			if (rate > longint'(cfg_max_rate))
				rate = longint'(cfg_max_rate);
			if (rate < longint'(cfg_min_rate))
				rate = 0;
			if (rate == 0) begin
				ramp_pulse = 1'b0;
			end else begin
				freq = rate << ramp_code;
				per = longint'(TIMER_RATE) / freq;
				if (per < 1)
					per = 1;
				if (per > PERIOD_CAP)
					per = PERIOD_CAP;
				ramp_period = PERIOD_W'(per);
				ramp_dir = (cur < 0);
				ramp_pulse = 1'b1;
			end
		end else if (req_op == OP_START) begin
			if (ramp_running) begin
				busy_start = 1'b1;
			end else begin
				ramp_running = 1'b1;
				ramp_code = (cfg_init_code > MAX_CODE) ? MAX_CODE : cfg_init_code;
			end
		end else if (req_op == OP_STOP && ramp_running) begin
			ramp_speed = '0;
			ramp_pulse = 1'b0;
			ramp_running = 1'b0;
		end
		r.pulse = ramp_pulse;
		r.dir = ramp_dir;
		r.period = ramp_period;
		r.pins = ramp_code;
		r.speed = ramp_speed;
		r.status = busy_start;
		ramp_expect_q.push_back(r);
	endfunction

	function automatic void push_req(input logic [1:0] o, input logic signed [TGT_W-1:0] t);
		ramp_req_t q;
		q.code = o;
		q.tgt = t;
		request_q.push_back(q);
		if (o == OP_START)
			gen_running = 1'b1;
		else if (o == OP_STOP)
			gen_running = 1'b0;
	endfunction

	function automatic logic signed [TGT_W-1:0] pick_target();
		int v;
		case ($urandom_range(0, 5))
			0: v = int'($urandom_range(0, 65535)) - 32768;
			1: v = int'($urandom_range(0, 1100));
			2: v = int'(cfg_max_rate) + int'($urandom_range(0, 4)) - 2;
			3: v = int'(cfg_min_rate) + int'($urandom_range(0, 2)) - 1;
			4: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
			default: v = int'($urandom_range(0, 60));
		endcase
		if ($urandom_range(0, 1) != 0)
			v = -v;
		return TGT_W'(v);
	endfunction

	function automatic logic signed [TGT_W-1:0] any_target();
		return TGT_W'($urandom_range(0, 65535));
	endfunction

	// mostly start/tick runs with held targets; some stops, repeat starts and noise
	function automatic void queue_random(input int unsigned n_reqs);
		int unsigned counted, pick, hold_left;
		logic signed [TGT_W-1:0] held;
		counted = 0;
		hold_left = 0;
		held = '0;
		while (counted < n_reqs) begin
			pick = $urandom_range(0, 99);
			if (!gen_running) begin
				if (pick < 85) begin
					push_req(OP_START, any_target());
					counted++;
				end else if (pick < 92)
					push_req(OP_TICK, any_target());
				else if (pick < 96)
					push_req(OP_STOP, any_target());
				else
					push_req(OP_UNUSED, any_target());
			end else begin
				if (pick < 88) begin
					if (hold_left == 0) begin
						held = pick_target();
						hold_left = $urandom_range(1, 30);
					end
					hold_left--;
					push_req(OP_TICK, held);
					counted++;
				end else if (pick < 93) begin
					push_req(OP_STOP, any_target());
					counted++;
				end else if (pick < 96) begin
					push_req(OP_START, any_target());
					counted++;
				end else
					push_req(OP_UNUSED, any_target());
			end
		end
	endfunction

	task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * idx);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MAX_RATE:  cfg_max_rate = val[RATE_W-1:0];
			REG_MIN_RATE:  cfg_min_rate = val[RATE_W-1:0];
			REG_MAX_DELTA: cfg_delta = val[DELTA_W-1:0];
			REG_INIT_CODE: cfg_init_code = val[CODE_W-1:0];
			default:       cfg_auto = val[0];
		endcase
	endtask

	task automatic program_config(input int unsigned max_rate, input int unsigned min_rate,
			input int unsigned delta, input int unsigned init_code, input int unsigned auto_ms);
		cfg_write(REG_MAX_RATE, max_rate);
		cfg_write(REG_MIN_RATE, min_rate);
		cfg_write(REG_MAX_DELTA, delta);
		cfg_write(REG_INIT_CODE, init_code);
		cfg_write(REG_AUTO, auto_ms);
	endtask

	// sampled at the falling edge so queue and valid state are settled
	task automatic wait_idle();
		@(negedge clk);
		while (request_q.size() != 0 || in_valid || ramp_expect_q.size() != 0)
			@(negedge clk);
	endtask

	// request driver: bursts, gaps and occasional full drain
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	logic drain_hold = 1'b0;
	ramp_req_t next_req;

	always @(posedge clk) begin
		if (in_valid && in_ready)
			predict_ramp(op, target_rate);
		if (!in_valid || in_ready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if ((drain_hold && ramp_expect_q.size() != 0) || request_q.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				next_req = request_q.pop_front();
				in_valid <= 1'b1;
				op <= next_req.code;
				target_rate <= next_req.tgt;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					drain_hold <= ($urandom_range(0, 7) == 0);
				end else begin
					burst_left <= burst_left - 1;
					drain_hold <= 1'b0;
				end
			end
		end
	end

	// result monitor with its own stall pattern
	int unsigned rcv_cyc = 0;
	int unsigned rcv_mode = 0;
	ramp_out_t want;

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (ramp_expect_q.size() == 0) begin
				log_mismatch("result with no request pending", 1, 0);
			end else begin
				want = ramp_expect_q.pop_front();
				if (pulse_active !== want.pulse)
					log_mismatch("pulse_active", longint'(pulse_active), longint'(want.pulse));
				if (direction !== want.dir)
					log_mismatch("direction", longint'(direction), longint'(want.dir));
				if (step_period !== want.period)
					log_mismatch("step_period", longint'(step_period), longint'(want.period));
				if (microstep_pins !== want.pins)
					log_mismatch("microstep_pins", longint'(microstep_pins),
						longint'(want.pins));
				if (speed_now !== want.speed)
					log_mismatch("speed_now", longint'(speed_now), longint'(want.speed));
				if (status !== want.status)
					log_mismatch("status", longint'(status), longint'(want.status));
			end
		end
		rcv_cyc <= rcv_cyc + 1;
		if (rcv_cyc % 300 == 0)
			rcv_mode <= $urandom_range(0, 4);
		case (rcv_mode)
			1: out_ready <= ($urandom_range(0, 1) != 0);
			2: out_ready <= (rcv_cyc % 7 == 0);
			3: out_ready <= ($urandom_range(0, 9) == 0);
			default: out_ready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: idle ops, double start, slow ramp up and partly back down, stop
		push_req(OP_TICK, 16'sd1234);
		push_req(OP_STOP, 16'sd0);
		push_req(OP_UNUSED, -16'sd1);
		push_req(OP_START, 16'sd0);
		push_req(OP_START, 16'sd0);
		repeat (5) push_req(OP_TICK, 16'sh7FFF);
		repeat (2) push_req(OP_TICK, 16'sh8000);
		push_req(OP_STOP, 16'sd0);
		wait_idle();

		// widest limits, auto microstep, saturating start code, threshold edges
		program_config(32767, 1, 8388607, 7, 1);
		push_req(OP_START, 16'sd0);
		push_req(OP_TICK, 16'sh7FFF);
		push_req(OP_TICK, 16'sh8000);
		push_req(OP_TICK, 16'sh8000);
		push_req(OP_TICK, 16'sd149);
		push_req(OP_TICK, 16'sd150);
		push_req(OP_TICK, 16'sd999);
		push_req(OP_TICK, 16'sd1000);
		push_req(OP_TICK, 16'sd0);

		for (int p = 0; p < 7; p++) begin
			wait_idle();
			case (p)
				0: program_config(32767, 32767, $urandom_range(1, 8388607),
					$urandom_range(0, 7), $urandom_range(0, 1));
				1: program_config(1, 1, 1, 0, 0);
				// zero ceiling: every rate clamps to zero
				2: program_config(0, $urandom_range(1, 300), $urandom_range(256, 65535),
					$urandom_range(0, 7), $urandom_range(0, 1));
				default: program_config(
					($urandom_range(0, 2) == 0) ? $urandom_range(1, 32767)
						: $urandom_range(100, 3000),
					($urandom_range(0, 3) == 0) ? $urandom_range(1, 32767)
						: $urandom_range(1, 300),
					($urandom_range(0, 2) == 0) ? $urandom_range(1, 4095)
						: (($urandom_range(0, 1) == 0) ? $urandom_range(4096, 262143)
						: $urandom_range(1, 8388607)),
					$urandom_range(0, 7), $urandom_range(0, 1));
			endcase
			queue_random(PHASE_REQS);
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ files.f @@
rtl/ssrc_pkg.sv
rtl/ssrc_div.sv
rtl/stepper_speed_ramp_controller.sv
tb/tb_stepper_speed_ramp_controller.sv
